>>> design/prst_pkg.sv
// Shared constants and sine table for the polygon transform block.
package prst_pkg;
  localparam int MaxVertsDef = 32;
  localparam logic [1:0] REG_ANGLE = 2'd0;
  localparam logic [1:0] REG_SCALE = 2'd1;
  localparam logic [1:0] REG_POSX  = 2'd2;
  localparam logic [1:0] REG_POSY  = 2'd3;

  typedef struct packed {
    logic load;       // accept a vertex
    logic start;      // begin centroid division
    logic div_step;   // centroid division iteration
    logic xf_fetch;   // issue a store read for the transform
    logic cap_start;  // take transform result as segment start
    logic cap_end;    // take transform result as segment end
    logic advance;    // segment taken: end becomes next start
    logic clear;      // run done: drop count, sums and overflow
  } prst_cmd_t;

  typedef struct packed {
    logic div_done;
  } prst_sts_t;

  function automatic logic [14:0] sin_q14(input logic [6:0] d);
    logic [14:0] t [0:90];
    t = '{15'd0,15'd286,15'd572,15'd857,15'd1143,15'd1428,15'd1713,15'd1997,15'd2280,
      15'd2563,15'd2845,15'd3126,15'd3406,15'd3686,15'd3964,15'd4240,15'd4516,15'd4790,
      15'd5063,15'd5334,15'd5604,15'd5872,15'd6138,15'd6402,15'd6664,15'd6924,15'd7182,
      15'd7438,15'd7692,15'd7943,15'd8192,15'd8438,15'd8682,15'd8923,15'd9162,15'd9397,
      15'd9630,15'd9860,15'd10087,15'd10311,15'd10531,15'd10749,15'd10963,15'd11174,
      15'd11381,15'd11585,15'd11786,15'd11982,15'd12176,15'd12365,15'd12551,15'd12733,
      15'd12911,15'd13085,15'd13255,15'd13421,15'd13583,15'd13741,15'd13894,15'd14044,
      15'd14189,15'd14330,15'd14466,15'd14598,15'd14726,15'd14849,15'd14968,15'd15082,
      15'd15191,15'd15296,15'd15396,15'd15491,15'd15582,15'd15668,15'd15749,15'd15826,
      15'd15897,15'd15964,15'd16026,15'd16083,15'd16135,15'd16182,15'd16225,15'd16262,
      15'd16294,15'd16322,15'd16344,15'd16362,15'd16374,15'd16382,15'd16384};
    return (d <= 7'd90) ? t[d] : 15'd0;
  endfunction
endpackage

>>> design/prst_datapath.sv
// Datapath: vertex store, sums, centroid divider and transform pipeline.
module prst_datapath #(
  parameter int MaxVerts = prst_pkg::MaxVertsDef,
  localparam int CW = $clog2(MaxVerts + 1),
  localparam int AW = (MaxVerts > 1) ? $clog2(MaxVerts) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  prst_pkg::prst_cmd_t cmd_i,
  output prst_pkg::prst_sts_t sts_o,
  input  logic signed [9:0]   vertex_x_i,
  input  logic signed [9:0]   vertex_y_i,
  input  logic [8:0]          angle_i,
  input  logic [11:0]         scale_i,
  input  logic signed [11:0]  pos_x_i,
  input  logic signed [11:0]  pos_y_i,
  input  logic [AW-1:0]       rd_idx_i,
  output logic signed [15:0]  start_x_o,
  output logic signed [15:0]  start_y_o,
  output logic signed [15:0]  end_x_o,
  output logic signed [15:0]  end_y_o,
  output logic [CW-1:0]       count_o,
  output logic                overflow_o
);
  import prst_pkg::*;

  logic [19:0] store_q [MaxVerts];
  logic [CW-1:0] count_q;
  logic signed [15:0] sum_x_q, sum_y_q;
  logic ovf_q;
  logic full;
  assign full = (count_q == CW'(MaxVerts));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) store_q[count_q[AW-1:0]] <= {vertex_y_i, vertex_x_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; sum_x_q <= '0; sum_y_q <= '0; ovf_q <= 1'b0;
    end else if (cmd_i.clear) begin
      count_q <= '0; sum_x_q <= '0; sum_y_q <= '0; ovf_q <= 1'b0;
    end else if (cmd_i.load) begin
      if (!full) begin
        count_q <= count_q + CW'(1);
        sum_x_q <= sum_x_q + 16'(vertex_x_i);
        sum_y_q <= sum_y_q + 16'(vertex_y_i);
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end
  assign count_o = count_q;
  assign overflow_o = ovf_q;

  // restoring divider: |sum|*256 / n, sign applied after (truncates toward zero)
  logic [23:0] quo_x_q, quo_y_q;
  logic [CW-1:0] rem_x_q, rem_y_q;
  logic [4:0]  dstep_q;
  logic [23:0] nx_mag, ny_mag;
  assign nx_mag = sum_x_q[15] ? 24'(-sum_x_q) << 8 : 24'(sum_x_q) << 8;
  assign ny_mag = sum_y_q[15] ? 24'(-sum_y_q) << 8 : 24'(sum_y_q) << 8;
  logic [CW:0] tx_r, ty_r;
  assign tx_r = {rem_x_q, quo_x_q[23]};
  assign ty_r = {rem_y_q, quo_y_q[23]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dstep_q <= '0; quo_x_q <= '0; quo_y_q <= '0; rem_x_q <= '0; rem_y_q <= '0;
    end else if (cmd_i.start) begin
      dstep_q <= '0; quo_x_q <= nx_mag; quo_y_q <= ny_mag;
      rem_x_q <= '0; rem_y_q <= '0;
    end else if (cmd_i.div_step && dstep_q != 5'd24) begin
      dstep_q <= dstep_q + 5'd1;
      if (tx_r >= {1'b0, count_q}) begin
        rem_x_q <= CW'(tx_r - {1'b0, count_q}); quo_x_q <= {quo_x_q[22:0], 1'b1};
      end else begin
        rem_x_q <= tx_r[CW-1:0]; quo_x_q <= {quo_x_q[22:0], 1'b0};
      end
      if (ty_r >= {1'b0, count_q}) begin
        rem_y_q <= CW'(ty_r - {1'b0, count_q}); quo_y_q <= {quo_y_q[22:0], 1'b1};
      end else begin
        rem_y_q <= ty_r[CW-1:0]; quo_y_q <= {quo_y_q[22:0], 1'b0};
      end
    end
  end
  assign sts_o.div_done = (dstep_q == 5'd24);

  logic signed [24:0] cx, cy;
  assign cx = sum_x_q[15] ? -$signed({1'b0, quo_x_q}) : $signed({1'b0, quo_x_q});
  assign cy = sum_y_q[15] ? -$signed({1'b0, quo_y_q}) : $signed({1'b0, quo_y_q});

  // sine/cosine
  logic [8:0] a; logic [1:0] q; logic [6:0] r;
  logic signed [15:0] s_v, c_v, lo, hi;
  always_comb begin
    a = (angle_i >= 9'd360) ? angle_i - 9'd360 : angle_i;
    if (a >= 9'd270) begin q = 2'd3; r = 7'(a - 9'd270); end
    else if (a >= 9'd180) begin q = 2'd2; r = 7'(a - 9'd180); end
    else if (a >= 9'd90) begin q = 2'd1; r = 7'(a - 9'd90); end
    else begin q = 2'd0; r = 7'(a); end
    lo = 16'(sin_q14(r)); hi = 16'(sin_q14(7'd90 - r));
    case (q)
      2'd0: begin s_v = lo; c_v = hi; end
      2'd1: begin s_v = hi; c_v = -lo; end
      2'd2: begin s_v = -lo; c_v = -hi; end
      default: begin s_v = -hi; c_v = lo; end
    endcase
  end

  // stage 0: store read
  logic [19:0] rd_q;
  always_ff @(posedge clk_i) if (cmd_i.xf_fetch) rd_q <= store_q[rd_idx_i];

  // stage 1: relative to centroid, truncated toward zero
  logic signed [25:0] dx, dy;
  logic signed [17:0] tx_q, ty_q;
  always_comb begin
    dx = 26'($signed(rd_q[9:0])) * 26'sd256 - 26'(cx);
    dy = 26'($signed(rd_q[19:10])) * 26'sd256 - 26'(cy);
  end
  function automatic logic signed [17:0] tdiv256(input logic signed [25:0] v);
    logic signed [25:0] t;
    t = v[25] ? v + 26'sd255 : v;
    return 18'(t >>> 8);
  endfunction

  // stage 2: products
  logic signed [33:0] pxc_q, pys_q, pxs_q, pyc_q;
  // stage 3: rotated and moved back
  logic signed [19:0] bx_q, by_q;
  logic signed [34:0] rxs, rys;
  logic signed [19:0] rx, ry;
  logic signed [35:0] bxs, bys;
  always_comb begin
    rxs = 35'(pxc_q) - 35'(pys_q);
    rys = 35'(pxs_q) + 35'(pyc_q);
    rx = 20'((rxs[34] ? rxs + 35'sd16383 : rxs) >>> 14);
    ry = 20'((rys[34] ? rys + 35'sd16383 : rys) >>> 14);
    bxs = 36'(rx) * 36'sd256 + 36'(cx);
    bys = 36'(ry) * 36'sd256 + 36'(cy);
  end
  // stage 4: scaled and offset
  logic signed [35:0] ox_q, oy_q;
  logic signed [35:0] fx, fy;
  always_comb begin
    fx = 36'(pos_x_i) * 36'sd256 + ox_q;
    fy = 36'(pos_y_i) * 36'sd256 + oy_q;
  end
  logic signed [35:0] gx, gy;
  assign gx = (fx[35] ? fx + 36'sd255 : fx) >>> 8;
  assign gy = (fy[35] ? fy + 36'sd255 : fy) >>> 8;

  // stage 5: saturated result
  logic signed [15:0] px_q, py_q;
  always_ff @(posedge clk_i) begin
    tx_q <= tdiv256(dx); ty_q <= tdiv256(dy);
    pxc_q <= 34'(tx_q) * 34'(c_v); pys_q <= 34'(ty_q) * 34'(s_v);
    pxs_q <= 34'(tx_q) * 34'(s_v); pyc_q <= 34'(ty_q) * 34'(c_v);
    bx_q <= 20'((bxs[35] ? bxs + 36'sd255 : bxs) >>> 8);
    by_q <= 20'((bys[35] ? bys + 36'sd255 : bys) >>> 8);
    ox_q <= 36'(bx_q) * 36'($signed({1'b0, scale_i}));
    oy_q <= 36'(by_q) * 36'($signed({1'b0, scale_i}));
    px_q <= (gx > 36'sd32767) ? 16'sh7fff : (gx < -36'sd32768) ? 16'sh8000 : 16'(gx);
    py_q <= (gy > 36'sd32767) ? 16'sh7fff : (gy < -36'sd32768) ? 16'sh8000 : 16'(gy);
  end

  // segment registers: the end point of one segment starts the next
  logic signed [15:0] sx_q, sy_q, ex_q, ey_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= '0; sy_q <= '0; ex_q <= '0; ey_q <= '0;
    end else begin
      if (cmd_i.cap_start) begin
        sx_q <= px_q; sy_q <= py_q;
      end else if (cmd_i.advance) begin
        sx_q <= ex_q; sy_q <= ey_q;
      end
      if (cmd_i.cap_end) begin
        ex_q <= px_q; ey_q <= py_q;
      end
    end
  end
  assign start_x_o = sx_q;
  assign start_y_o = sy_q;
  assign end_x_o = ex_q;
  assign end_y_o = ey_q;
endmodule

>>> design/prst_ctrl.sv
// Controller: load, centroid division, transform sequencing and segment output.
module prst_ctrl #(
  parameter int MaxVerts = prst_pkg::MaxVertsDef,
  localparam int CW = $clog2(MaxVerts + 1),
  localparam int AW = (MaxVerts > 1) ? $clog2(MaxVerts) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                last_vertex_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                last_segment_o,
  output prst_pkg::prst_cmd_t cmd_o,
  input  prst_pkg::prst_sts_t sts_i,
  input  logic [CW-1:0]       count_i,
  output logic [AW-1:0]       rd_idx_o
);
  import prst_pkg::*;
  localparam logic [2:0] S_LOAD = 3'd0, S_INIT = 3'd1, S_DIV = 3'd2, S_XF = 3'd3,
    S_WAIT = 3'd4, S_OUT = 3'd5;
  // transform result sits at the datapath output on this wait count
  localparam logic [2:0] XfLat = 3'd5;
  logic [2:0] st_q, st_d;
  logic [CW-1:0] idx_q, nxt_idx;
  logic [2:0] wt_q;
  logic first_q;
  logic acc, last_idx, xf_done, adv;
  assign in_stall_o = (st_q != S_LOAD);
  assign acc = in_valid_i && !in_stall_o;
  assign last_idx = (idx_q == count_i - CW'(1));
  assign nxt_idx = last_idx ? '0 : idx_q + CW'(1);
  assign xf_done = (st_q == S_WAIT) && (wt_q == XfLat);
  assign adv = (st_q == S_OUT) && !out_stall_i;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_LOAD: if (acc && last_vertex_i) st_d = S_INIT;
      S_INIT: st_d = S_DIV;
      S_DIV: if (sts_i.div_done) st_d = S_XF;
      S_XF: st_d = S_WAIT;
      S_WAIT: if (wt_q == XfLat) st_d = first_q ? S_XF : S_OUT;
      S_OUT: if (!out_stall_i) st_d = last_idx ? S_LOAD : S_XF;
      default: st_d = S_LOAD;
    endcase
  end

  // vertex 0 is transformed once as the first start; each segment then fetches its end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD; idx_q <= '0; wt_q <= '0; first_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == S_INIT) begin
        idx_q <= '0; first_q <= 1'b1;
      end else if (adv) begin
        idx_q <= nxt_idx;
      end
      if (xf_done) first_q <= 1'b0;
      if (st_q == S_WAIT) wt_q <= wt_q + 3'd1;
      else wt_q <= '0;
    end
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.load = acc;
    cmd_o.start = (st_q == S_INIT);
    cmd_o.div_step = (st_q == S_DIV);
    cmd_o.xf_fetch = (st_q == S_XF);
    cmd_o.cap_start = xf_done && first_q;
    cmd_o.cap_end = xf_done && !first_q;
    cmd_o.advance = adv;
    cmd_o.clear = adv && last_idx;
  end
  assign rd_idx_o = first_q ? '0 : nxt_idx[AW-1:0];
  assign out_valid_o = (st_q == S_OUT);
  assign last_segment_o = (st_q == S_OUT) && last_idx;
endmodule

>>> design/polygon_rotate_scale_translate.sv
// Top level: polygon rotate, scale, translate to closed-loop segments.
// Vertices load one per cycle while in_stall_o is low; the beat carrying last_vertex starts the run.
// The first segment follows a setup step, the centroid division and then two transforms
// (start and end). Each later segment is fetched and transformed after the previous one
// is taken. Input is stalled until the closing segment is taken.
// rst_ni clears control state, sums, counts and config; the vertex store is not reset.
module polygon_rotate_scale_translate #(
  parameter int MaxVerts = prst_pkg::MaxVertsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [9:0]  vertex_x_i,
  input  logic signed [9:0]  vertex_y_i,
  input  logic               last_vertex_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] start_x_o,
  output logic signed [15:0] start_y_o,
  output logic signed [15:0] end_x_o,
  output logic signed [15:0] end_y_o,
  output logic               last_segment_o,
  output logic               overflow_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [11:0]        cfg_data_i
);
  import prst_pkg::*;
  logic [8:0] angle_q; logic [11:0] scale_q; logic signed [11:0] posx_q, posy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0; scale_q <= 12'd256; posx_q <= '0; posy_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ANGLE: angle_q <= cfg_data_i[8:0];
        REG_SCALE: scale_q <= cfg_data_i;
        REG_POSX:  posx_q <= cfg_data_i;
        REG_POSY:  posy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  localparam int CW = $clog2(MaxVerts + 1);
  localparam int AW = (MaxVerts > 1) ? $clog2(MaxVerts) : 1;
  prst_cmd_t cmd; prst_sts_t sts;
  logic [CW-1:0] count;
  logic [AW-1:0] rd_idx;

  prst_ctrl #(.MaxVerts(MaxVerts)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .last_vertex_i, .in_stall_o,
    .out_valid_o, .out_stall_i, .last_segment_o, .cmd_o(cmd), .sts_i(sts),
    .count_i(count), .rd_idx_o(rd_idx));

  prst_datapath #(.MaxVerts(MaxVerts)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .vertex_x_i, .vertex_y_i,
    .angle_i(angle_q), .scale_i(scale_q), .pos_x_i(posx_q), .pos_y_i(posy_q),
    .rd_idx_i(rd_idx), .start_x_o, .start_y_o, .end_x_o, .end_y_o,
    .count_o(count), .overflow_o);

  a_no_load_during_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
    $stable({start_x_o, start_y_o, end_x_o, end_y_o, last_segment_o, overflow_o}));
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_segment_o |-> out_valid_o);
endmodule

>>> tb/tb_polygon_rotate_scale_translate.sv
// Testbench for the polygon rotate/scale/translate block: directed table plus random polygons.
module tb_polygon_rotate_scale_translate;
  timeunit 1ns;
  timeprecision 1ps;
  import prst_pkg::*;

  localparam int NVerts = MaxVertsDef;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic signed [15:0] sx, sy, ex, ey;
    logic               last_seg, ovf;
  } segment_t;

  typedef struct {
    logic signed [9:0] vx, vy;
    logic              last;
    logic              typed;   // expected segment below is given directly
    segment_t          seg;
  } vrow_t;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic in_valid_i = 1'b0, out_stall_i = 1'b0, last_vertex_i = 1'b0;
  logic signed [9:0] vertex_x_i = '0, vertex_y_i = '0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = REG_ANGLE;
  logic [11:0] cfg_data_i = '0;
  logic in_stall_o, out_valid_o, last_segment_o, overflow_o;
  logic signed [15:0] start_x_o, start_y_o, end_x_o, end_y_o;

  polygon_rotate_scale_translate dut (.*);

  initial forever #10 clk_i = ~clk_i;

  // predictor state
  logic [8:0]  m_angle = 9'd0;
  logic [11:0] m_scale = 12'd256;
  logic signed [11:0] m_posx = '0, m_posy = '0;
  logic signed [9:0] poly_x[NVerts], poly_y[NVerts];
  int poly_cnt = 0, poly_sx = 0, poly_sy = 0;
  bit poly_ovf = 0;

  segment_t seg_q[$];
  int n_errs = 0, n_segs = 0, n_polys = 0, cycles = 0, stall_left = 0;
  bit quiet = 0, pending_typed = 0;
  segment_t typed_seg;

  function automatic longint tdiv(longint a, longint b);
    longint q;
    q = (a < 0 ? -a : a) / (b < 0 ? -b : b);
    return ((a < 0) != (b < 0)) ? -q : q;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  int sine_tab[91] = '{0,286,572,857,1143,1428,1713,1997,2280,2563,2845,3126,3406,3686,
    3964,4240,4516,4790,5063,5334,5604,5872,6138,6402,6664,6924,7182,7438,7692,7943,8192,
    8438,8682,8923,9162,9397,9630,9860,10087,10311,10531,10749,10963,11174,11381,11585,
    11786,11982,12176,12365,12551,12733,12911,13085,13255,13421,13583,13741,13894,14044,
    14189,14330,14466,14598,14726,14849,14968,15082,15191,15296,15396,15491,15582,15668,
    15749,15826,15897,15964,16026,16083,16135,16182,16225,16262,16294,16322,16344,16362,
    16374,16382,16384};

  task automatic place_vertex(input int idx, input longint cx, input longint cy,
                              input longint s, input longint c,
                              output logic signed [15:0] ox, output logic signed [15:0] oy);
    longint tx, ty, rx, ry, bx, by;
    tx = tdiv(longint'(poly_x[idx]) * 256 - cx, 256);
    ty = tdiv(longint'(poly_y[idx]) * 256 - cy, 256);
    rx = tdiv(tx * c - ty * s, 16384);
    ry = tdiv(tx * s + ty * c, 16384);
    bx = tdiv(rx * 256 + cx, 256);
    by = tdiv(ry * 256 + cy, 256);
    ox = clamp16(tdiv(longint'(m_posx) * 256 + bx * longint'(m_scale), 256));
    oy = clamp16(tdiv(longint'(m_posy) * 256 + by * longint'(m_scale), 256));
  endtask

  // fold one accepted vertex into the model; emit segments on the last flag
  task automatic absorb_vertex(input logic signed [9:0] vx, input logic signed [9:0] vy,
                               input logic last);
    int a, r;
    longint cx, cy, s, c, lo, hi;
    segment_t sg;
    logic signed [15:0] ax, ay, bx, by;
    if (poly_cnt < NVerts) begin
      poly_x[poly_cnt] = vx;
      poly_y[poly_cnt] = vy;
      poly_sx += vx;
      poly_sy += vy;
      poly_cnt++;
    end else poly_ovf = 1;
    if (!last || poly_cnt == 0) return;
    cx = tdiv(longint'(16'(poly_sx)) * 256, poly_cnt);
    cy = tdiv(longint'(16'(poly_sy)) * 256, poly_cnt);
    a = m_angle % 360;
    r = a % 90;
    lo = sine_tab[r];
    hi = sine_tab[90 - r];
    case (a / 90)
      0: begin s = lo; c = hi; end
      1: begin s = hi; c = -lo; end
      2: begin s = -lo; c = -hi; end
      default: begin s = -hi; c = lo; end
    endcase
    for (int i = 0; i < poly_cnt; i++) begin
      place_vertex(i, cx, cy, s, c, ax, ay);
      place_vertex((i + 1 == poly_cnt) ? 0 : i + 1, cx, cy, s, c, bx, by);
      sg.sx = ax; sg.sy = ay; sg.ex = bx; sg.ey = by;
      sg.last_seg = (i + 1 == poly_cnt);
      sg.ovf = poly_ovf;
      seg_q = {seg_q, sg};
    end
    n_polys++;
    poly_cnt = 0; poly_sx = 0; poly_sy = 0; poly_ovf = 0;
  endtask

  task automatic report(input string what, input segment_t e);
    n_errs++;
    if (n_errs <= 10)
      $display("mismatch %s: exp %0d %0d %0d %0d l%0b o%0b got %0d %0d %0d %0d l%0b o%0b",
        what, e.sx, e.sy, e.ex, e.ey, e.last_seg, e.ovf, start_x_o, start_y_o,
        end_x_o, end_y_o, last_segment_o, overflow_o);
  endtask

  // output checker and receiver stall
  always @(posedge clk_i) begin
    segment_t e;
    cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_segs++;
      if (seg_q.size() == 0) report("unexpected segment", e);
      else begin
        e = seg_q.pop_front();
        if (pending_typed) begin
          pending_typed = 0;
          if (typed_seg != e) report("typed row", typed_seg);
        end
        if (start_x_o !== e.sx || start_y_o !== e.sy || end_x_o !== e.ex ||
            end_y_o !== e.ey || last_segment_o !== e.last_seg || overflow_o !== e.ovf)
          report("segment", e);
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = int'($urandom_range(0, 4));
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
    if (cycles > CycleLimit) begin
      $display("timeout");
      $display("tb_polygon_rotate_scale_translate: FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ANGLE: m_angle = val[8:0];
      REG_SCALE: m_scale = val;
      REG_POSX:  m_posx = val;
      default:   m_posy = val;
    endcase
  endtask

  task automatic drain();
    while (seg_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // drive one vertex beat; valid stays up between back-to-back beats
  task automatic send_vertex(input logic signed [9:0] vx, input logic signed [9:0] vy,
                             input logic last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    vertex_x_i <= vx; vertex_y_i <= vy; last_vertex_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    absorb_vertex(vx, vy, last);
  endtask

  task automatic random_polygon(input int nv);
    for (int i = 0; i < nv; i++)
      send_vertex(10'($urandom), 10'($urandom), i == nv - 1);
  endtask

  vrow_t rows[$];
  vrow_t rw;

  initial begin
    // directed table: typed rows are single-vertex polygons at reset settings
    rows = '{
      '{10'sd0, 10'sd0, 1'b1, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0}},
      '{10'sd511, 10'sd511, 1'b1, 1'b1, '{16'sd511, 16'sd511, 16'sd511, 16'sd511, 1'b1, 1'b0}},
      '{-10'sd512, -10'sd512, 1'b1, 1'b1,
        '{-16'sd512, -16'sd512, -16'sd512, -16'sd512, 1'b1, 1'b0}},
      '{10'sd100, -10'sd50, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{-10'sd100, 10'sd50, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{10'sd7, 10'sd300, 1'b1, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{10'sd511, -10'sd512, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}},
      '{-10'sd512, 10'sd511, 1'b1, 1'b0, '{0, 0, 0, 0, 0, 0}}
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[k]) begin
      rw = rows[k];
      if (rw.typed) begin
        typed_seg = rw.seg;
        pending_typed = 1;
      end
      send_vertex(rw.vx, rw.vy, rw.last);
      if (rw.typed) begin
        in_valid_i <= 1'b0;
        drain();
      end
    end
    in_valid_i <= 1'b0;
    drain();
    // large scale and offsets to reach saturation, odd angle
    write_reg(REG_ANGLE, 12'd45);
    write_reg(REG_SCALE, 12'd4095);
    write_reg(REG_POSX, 12'h7FF);
    write_reg(REG_POSY, 12'h800);
    random_polygon(4);
    // store overflow: 34 vertices, last two dropped but the final one still closes the run
    random_polygon(34);
    in_valid_i <= 1'b0;
    drain();
    // random phases with fresh settings, including extreme ones
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(REG_ANGLE, 12'd359); write_reg(REG_SCALE, 12'd0); end
        1: begin write_reg(REG_ANGLE, 12'd511); write_reg(REG_SCALE, 12'd256); end
        default: begin
          write_reg(REG_ANGLE, 12'($urandom_range(0, 511)));
          write_reg(REG_SCALE, 12'($urandom));
        end
      endcase
      write_reg(REG_POSX, 12'($urandom));
      write_reg(REG_POSY, 12'($urandom));
      if (ph == 4) quiet = 1;
      for (int p = 0; p < 3; p++)
        random_polygon(($urandom_range(0, 9) == 0) ? int'($urandom_range(30, 36))
                                                    : int'($urandom_range(1, 6)));
      in_valid_i <= 1'b0;
      drain();
    end
    $display("covered %0d polygons, %0d segments, all angles quadrants and saturation",
             n_polys, n_segs);
    if (n_errs == 0 && seg_q.size() == 0) $display("tb_polygon_rotate_scale_translate: PASS");
    else begin
      $display("%0d mismatches, %0d left over", n_errs, seg_q.size());
      $display("tb_polygon_rotate_scale_translate: FAIL");
    end
    $finish;
  end
endmodule

>>> filelist.f
design/prst_pkg.sv
design/prst_datapath.sv
design/prst_ctrl.sv
design/polygon_rotate_scale_translate.sv
tb/tb_polygon_rotate_scale_translate.sv
